// ===== hdl/dfca_pkg.sv =====
// Shared types, constants and codes for the decoder feed channel arbiter.
`default_nettype none

package dfca_pkg;

   localparam int CHANNELS = 3;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [30:0] ELAPSE_LIMIT   = 31'h7F00_0000;
   localparam logic [30:0] MAX_BUSY_RESET = 31'd90000;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 40;

   localparam int          CSR_ADDR_W   = 3;
   localparam logic [2:0]  CSR_MAX_BUSY = 3'd0;

   typedef enum logic [1:0] {
      CMD_REPORT = 2'd0,
      CMD_CHECK  = 2'd1,
      CMD_SENT   = 2'd2,
      CMD_OPEN   = 2'd3
   } command_type;

   // Per-channel record held in the state RAM.
   typedef struct packed {
      logic        mark_valid;
      logic [30:0] mark_time;
      logic [31:0] busy_total;
      logic        sent_pending;
      logic [7:0]  units;
      logic [5:0]  free_cnt;
      logic        ready;
   } rec_type;

   localparam rec_type REC_RESET = '{
      mark_valid:   1'b0,
      mark_time:    31'd0,
      busy_total:   32'd0,
      sent_pending: 1'b0,
      units:        8'd0,
      free_cnt:     6'd0,
      ready:        1'b1
   };

   // Round candidate.
   typedef struct packed {
      logic                valid;
      logic [CH_IDX_W-1:0] ch;
      logic [5:0]          free_cnt;
      logic [5:0]          active_cnt;
      logic                ready;
   } best_type;

   localparam best_type BEST_RESET = '0;

endpackage

`default_nettype wire

// ===== hdl/dfca_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dfca_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 4,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_W-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_W-1:0]    rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the contents before a write in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/decoder_feed_channel_arbiter.sv =====
// Top level of the decoder feed channel arbiter: round selection and busy-time tracking.
//
//  channel   dir  handshake               payload
//  req_      in   tvalid/tready           tuser command, tdata status, tlast last_in_round
//  rsp_      out  tvalid/tready           tdata grant and busy time, tlast round_done
//  csr_      in   APB psel/penable        max_busy_time at byte address 0
//
// One word per cycle unless the result stage stalls; a word passes the stage 1 and result
// registers. The figure is set by the single read port of the channel record RAM: the
// record is read at accept, modified and written back as the word leaves stage 1, and a
// word that follows at once on the same channel takes the written record from a forwarding
// register. Reset is synchronous; per-entry valid bits make unwritten records read as their
// reset value, so there is no clearing pass. A stalled result stage holds the pipeline.
`default_nettype none

module decoder_feed_channel_arbiter (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Input words.
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // tdata from bit 0 up: channel[1:0], pending_units[9:2], active_slots[15:10],
   // free_slots[21:16], ready_req[22], now[53:23], zero fill[55:54]
   input  wire logic [dfca_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: command[1:0]
   input  wire logic [1:0]                       req_tuser,
   input  wire logic                             req_tlast,
   // Result words.
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // tdata from bit 0 up: grant_valid[0], grant_channel[2:1], reset_request[3],
   // busy_time[35:4], zero fill[39:36]
   output logic      [dfca_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                                  rsp_tlast,
   // Configuration.
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [dfca_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                      csr_pwdata,
   output logic      [31:0]                      csr_prdata,
   output logic                                  csr_pready
);

   localparam int IW = dfca_pkg::CH_IDX_W;

   // ------------------------------------------------------------------
   // Configuration register
   // ------------------------------------------------------------------
   logic [30:0] max_busy_ff;
   logic [30:0] max_busy_in;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      max_busy_in = max_busy_ff;
      if (csr_wr && csr_paddr == dfca_pkg::CSR_MAX_BUSY) begin
         max_busy_in = csr_pwdata[30:0];
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr == dfca_pkg::CSR_MAX_BUSY) begin
         csr_prdata = {1'b0, max_busy_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_busy_ff <= dfca_pkg::MAX_BUSY_RESET;
      end else begin
         max_busy_ff <= max_busy_in;
      end
   end

   // ------------------------------------------------------------------
   // Handshake and pipeline control
   // ------------------------------------------------------------------
   logic s1_vld_ff, s1_vld_in;
   logic rsp_vld_ff, rsp_vld_in;
   logic s1_adv;
   logic accept;

   // Advance stage 1 whenever the result register is free or being drained.
   assign s1_adv     = s1_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (accept) begin
         s1_vld_in = 1'b1;
      end else if (s1_adv) begin
         s1_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (s1_adv) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1 word registers
   // ------------------------------------------------------------------
   dfca_pkg::command_type s1_cmd_ff;
   logic [IW-1:0]         s1_addr_ff;
   logic                  s1_inrange_ff;
   logic [7:0]            s1_units_ff;
   logic [5:0]            s1_act_ff;
   logic [5:0]            s1_free_ff;
   logic                  s1_rdy_ff;
   logic [30:0]           s1_now_ff;
   logic                  s1_last_ff;

   logic [1:0]            req_chan;
   logic [IW-1:0]         req_addr;

   assign req_chan = req_tdata[1:0];
   assign req_addr = IW'(req_chan);

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff     <= dfca_pkg::command_type'(req_tuser);
         s1_addr_ff    <= req_addr;
         s1_inrange_ff <= 32'(req_chan) < dfca_pkg::CHANNELS;
         s1_units_ff   <= req_tdata[9:2];
         s1_act_ff     <= req_tdata[15:10];
         s1_free_ff    <= req_tdata[21:16];
         s1_rdy_ff     <= req_tdata[22];
         s1_now_ff     <= req_tdata[53:23];
         s1_last_ff    <= req_tlast;
      end
   end

   // ------------------------------------------------------------------
   // Channel record RAM, entry valid bits and write-back forwarding
   // ------------------------------------------------------------------
   dfca_pkg::rec_type       ram_rd;
   dfca_pkg::rec_type       rec_cur;
   dfca_pkg::rec_type       rec_nxt;
   dfca_pkg::rec_type       fwd_rec_ff;
   logic [IW-1:0]           fwd_addr_ff;
   logic                    fwd_vld_ff, fwd_vld_in;
   logic [dfca_pkg::CHANNELS-1:0] ent_vld_ff, ent_vld_in;
   logic                    ram_we;

   assign ram_we = s1_adv && s1_inrange_ff;

   dfca_ram #(
      .WIDTH ($bits(dfca_pkg::rec_type)),
      .DEPTH (dfca_pkg::CHANNELS)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_addr_ff),
      .wr_data (rec_nxt),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (ram_rd)
   );

   // A write at the edge that also read the RAM missed that read: forward it.
   always_comb begin
      fwd_vld_in = fwd_vld_ff;
      if (accept) begin
         fwd_vld_in = ram_we;
      end
      ent_vld_in = ent_vld_ff;
      if (ram_we) begin
         ent_vld_in[s1_addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_rec_ff  <= rec_nxt;
         fwd_addr_ff <= s1_addr_ff;
      end
   end

   always_comb begin
      if (fwd_vld_ff && fwd_addr_ff == s1_addr_ff) begin
         rec_cur = fwd_rec_ff;
      end else if (ent_vld_ff[s1_addr_ff]) begin
         rec_cur = ram_rd;
      end else begin
         rec_cur = dfca_pkg::REC_RESET;
      end
   end

   // ------------------------------------------------------------------
   // Record update and round selection
   // ------------------------------------------------------------------
   dfca_pkg::best_type best_ff, best_in;
   logic               qual;
   logic [30:0]        elapse;
   logic               grant_vld;
   logic [1:0]         grant_ch;
   logic               done;
   logic               rst_req;
   logic [31:0]        busy_out;

   assign qual   = (s1_units_ff != 8'd0) && (s1_free_ff != 6'd0);
   assign elapse = s1_now_ff - rec_cur.mark_time;

   always_comb begin
      rec_nxt   = rec_cur;
      best_in   = best_ff;
      grant_vld = 1'b0;
      grant_ch  = 2'd0;
      done      = 1'b0;
      rst_req   = 1'b0;
      unique case (s1_cmd_ff)
         dfca_pkg::CMD_REPORT: begin
            if (s1_inrange_ff) begin
               rec_nxt.units    = s1_units_ff;
               rec_nxt.free_cnt = s1_free_ff;
               rec_nxt.ready    = s1_rdy_ff;
               if (qual) begin
                  if (s1_free_ff > best_ff.free_cnt) begin
                     best_in = '{valid: 1'b1, ch: s1_addr_ff, free_cnt: s1_free_ff,
                                 active_cnt: s1_act_ff, ready: s1_rdy_ff};
                  end else if (s1_free_ff == best_ff.free_cnt && s1_rdy_ff &&
                               (!best_ff.ready || s1_act_ff > best_ff.active_cnt)) begin
                     best_in = '{valid: 1'b1, ch: s1_addr_ff, free_cnt: best_ff.free_cnt,
                                 active_cnt: s1_act_ff, ready: 1'b1};
                  end
               end
               // Close the open busy interval; drop implausible jumps.
               if (rec_cur.mark_valid && elapse <= dfca_pkg::ELAPSE_LIMIT) begin
                  rec_nxt.busy_total = rec_cur.busy_total + {1'b0, elapse};
               end
               rec_nxt.mark_valid = qual && !s1_rdy_ff;
               rec_nxt.mark_time  = (qual && !s1_rdy_ff) ? s1_now_ff : 31'd0;
               if (s1_units_ff != 8'd0) begin
                  rec_nxt.sent_pending = 1'b1;
               end
            end
            if (s1_last_ff) begin
               done = 1'b1;
               if (best_in.valid && best_in.ready) begin
                  grant_vld = 1'b1;
                  grant_ch  = 2'(best_in.ch);
               end
               best_in = dfca_pkg::BEST_RESET;
            end
         end
         dfca_pkg::CMD_CHECK: begin
            if (s1_inrange_ff && rec_cur.sent_pending &&
                rec_cur.busy_total <= {1'b0, dfca_pkg::ELAPSE_LIMIT} &&
                rec_cur.busy_total > {1'b0, max_busy_ff} &&
                rec_cur.units != 8'd0 && rec_cur.free_cnt != 6'd0 && !rec_cur.ready) begin
               rst_req              = 1'b1;
               rec_nxt.sent_pending = 1'b0;
               rec_nxt.busy_total   = 32'd0;
               rec_nxt.mark_valid   = 1'b0;
               rec_nxt.mark_time    = 31'd0;
            end
         end
         dfca_pkg::CMD_SENT: begin
            rec_nxt.sent_pending = 1'b1;
            rec_nxt.busy_total   = 32'd0;
            rec_nxt.mark_valid   = 1'b0;
            rec_nxt.mark_time    = 31'd0;
            if (rec_cur.units != 8'd0) begin
               rec_nxt.units = rec_cur.units - 8'd1;
            end
         end
         dfca_pkg::CMD_OPEN: begin
            rec_nxt = dfca_pkg::REC_RESET;
         end
         default: begin
            rec_nxt = rec_cur;
         end
      endcase
      busy_out = s1_inrange_ff ? rec_nxt.busy_total : 32'd0;
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   localparam int RSP_FILL_W = dfca_pkg::RSP_DATA_W - 36;
   logic [RSP_FILL_W-1:0] unused_fill;
   logic [35:0] rsp_word_ff;
   logic        rsp_last_ff;

   assign unused_fill = '0;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_word_ff <= {busy_out, rst_req, grant_ch, grant_vld};
         rsp_last_ff <= done;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {unused_fill, rsp_word_ff};
   assign rsp_tlast  = rsp_last_ff;

   // ------------------------------------------------------------------
   // Control state
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         fwd_vld_ff <= 1'b0;
         ent_vld_ff <= '0;
         best_ff    <= dfca_pkg::BEST_RESET;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         fwd_vld_ff <= fwd_vld_in;
         ent_vld_ff <= ent_vld_in;
         if (s1_adv) begin
            best_ff <= best_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/dfca_checker.sv =====
// Port-level assertions for the decoder feed channel arbiter, with its bind.
`default_nettype none

module dfca_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic [dfca_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  wire logic                             rsp_tlast
);

   // A grant only ends a round.
   a_grant_on_round_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tlast)
      else $error("grant outside round end");

   // A granted channel is one that exists.
   a_grant_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> 32'(rsp_tdata[2:1]) < dfca_pkg::CHANNELS)
      else $error("grant names a missing channel");

   // A reset request clears busy time and never comes with a grant.
   a_reset_clears_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[35:4] == 32'd0 && !rsp_tdata[0] && !rsp_tlast)
      else $error("reset request with busy time or grant");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

endmodule

bind decoder_feed_channel_arbiter dfca_checker u_dfca_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
